>>> hw/rtl/rtcrf_pkg.sv
// Package for the RTC register file: beat layouts, register indexes,
// write masks and the divide-by-ten helpers. No dependencies.
package rtcrf_pkg;

    localparam int ADDR_W    = 6;
    localparam int IDX_W     = 4;
    localparam int NIB_W     = 4;
    localparam int RDATA_W   = 8;
    localparam int MEM_DEPTH = 13;
    localparam int CTRL_NUM  = 3;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 8;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [APB_ADDR_W-1:0] REG_CHIP_TYPE = '0;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // register indexes
    localparam logic [IDX_W-1:0] IDX_SEC_LO  = 4'd0;
    localparam logic [IDX_W-1:0] IDX_SEC_HI  = 4'd1;
    localparam logic [IDX_W-1:0] IDX_MIN_LO  = 4'd2;
    localparam logic [IDX_W-1:0] IDX_MIN_HI  = 4'd3;
    localparam logic [IDX_W-1:0] IDX_HR_LO   = 4'd4;
    localparam logic [IDX_W-1:0] IDX_HR_HI   = 4'd5;
    localparam logic [IDX_W-1:0] IDX_6       = 4'd6;
    localparam logic [IDX_W-1:0] IDX_7       = 4'd7;
    localparam logic [IDX_W-1:0] IDX_8       = 4'd8;
    localparam logic [IDX_W-1:0] IDX_9       = 4'd9;
    localparam logic [IDX_W-1:0] IDX_10      = 4'd10;
    localparam logic [IDX_W-1:0] IDX_11      = 4'd11;
    localparam logic [IDX_W-1:0] IDX_12      = 4'd12;
    localparam logic [IDX_W-1:0] IDX_CTRL0   = 4'd13;
    localparam logic [IDX_W-1:0] IDX_CTRL1   = 4'd14;
    localparam logic [IDX_W-1:0] IDX_CTRL2   = 4'd15;

    // write masks
    localparam logic [NIB_W-1:0] CTRL0_MASK_A  = 4'h9;
    localparam logic [NIB_W-1:0] ALARM_MASK_3B = 4'h7;
    localparam logic [NIB_W-1:0] ALARM_MASK_2B = 4'h3;
    localparam logic [NIB_W-1:0] ALARM_MASK_1B = 4'h1;

    localparam logic [RDATA_W-1:0] PM_FLAG_A = 8'h04;
    localparam logic [RDATA_W-1:0] PM_FLAG_B = 8'h02;

    typedef struct packed {
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [4:0] hours;
        logic [4:0] day_of_month;
        logic [3:0] month_index;
        logic [7:0] years_since_1900;
        logic [2:0] weekday;
    } t_time;

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] byte_address;
        logic [7:0]        write_data;
        t_time             tm;
    } t_item;

    // state seen by the read path
    typedef struct packed {
        logic [NIB_W-1:0] ctrl0;
        logic [NIB_W-1:0] ctrl1;
        logic [NIB_W-1:0] ctrl2;
        logic [NIB_W-1:0] mem_nib;
        logic [NIB_W-1:0] alarm_sel;
        logic             alarm10_b0;
    } t_regs_view;

    // quotient by ten through reciprocal, exact for every 8-bit x
    function automatic logic [4:0] div10_q(logic [7:0] x);
        logic [15:0] p;
        p = 16'(x) * 16'd205;
        return p[15:11];
    endfunction

    function automatic logic [3:0] div10_r(logic [7:0] x);
        logic [7:0] q;
        logic [7:0] d;
        q = 8'(div10_q(x));
        d = x - 8'(q * 8'd10);
        return d[3:0];
    endfunction

endpackage

>>> hw/rtl/rtcrf_regs.sv
// Control registers, banked nibble memory and alarm store with write decode.
// Depends on rtcrf_pkg.
module rtcrf_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_chip_type,
    input  logic                          i_wr_en,
    input  logic [rtcrf_pkg::IDX_W-1:0]   i_idx,
    input  logic [rtcrf_pkg::NIB_W-1:0]   i_wdata,
    output rtcrf_pkg::t_regs_view         o_view
);

    logic [rtcrf_pkg::NIB_W-1:0] r_ctrl  [rtcrf_pkg::CTRL_NUM];
    logic [7:0]                  r_mem   [rtcrf_pkg::MEM_DEPTH];
    logic [rtcrf_pkg::NIB_W-1:0] r_alarm [rtcrf_pkg::MEM_DEPTH];

    logic       in_range;
    logic [1:0] bank;
    logic [1:0] cidx;
    logic [7:0] mem_rd;

    assign in_range = i_idx < rtcrf_pkg::IDX_CTRL0;
    assign bank     = r_ctrl[0][1:0];
    assign cidx     = 2'(i_idx - rtcrf_pkg::IDX_CTRL0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rtcrf_pkg::CTRL_NUM; i++) begin
                r_ctrl[i] <= '0;
            end
            for (int i = 0; i < rtcrf_pkg::MEM_DEPTH; i++) begin
                r_mem[i]   <= '0;
                r_alarm[i] <= '0;
            end
        end else if (i_wr_en) begin
            if (!i_chip_type) begin
                if (i_idx == rtcrf_pkg::IDX_CTRL0) begin
                    r_ctrl[0] <= i_wdata & rtcrf_pkg::CTRL0_MASK_A;
                end else if (!in_range) begin
                    r_ctrl[cidx] <= i_wdata;
                end
            end else if (!in_range) begin
                r_ctrl[cidx] <= i_wdata;
            end else if (bank[1]) begin
                if (bank[0]) begin
                    r_mem[i_idx][7:4] <= i_wdata;
                end else begin
                    r_mem[i_idx][3:0] <= i_wdata;
                end
            end else if (bank[0]) begin
                case (i_idx)
                    rtcrf_pkg::IDX_SEC_LO, rtcrf_pkg::IDX_SEC_HI,
                    rtcrf_pkg::IDX_9, rtcrf_pkg::IDX_12: begin
                        r_alarm[i_idx] <= '0;
                    end
                    rtcrf_pkg::IDX_MIN_HI, rtcrf_pkg::IDX_6: begin
                        r_alarm[i_idx] <= r_alarm[i_idx] & i_wdata & rtcrf_pkg::ALARM_MASK_3B;
                    end
                    rtcrf_pkg::IDX_HR_HI, rtcrf_pkg::IDX_8, rtcrf_pkg::IDX_11: begin
                        r_alarm[i_idx] <= i_wdata & rtcrf_pkg::ALARM_MASK_2B;
                    end
                    rtcrf_pkg::IDX_10: begin
                        r_alarm[i_idx] <= i_wdata & rtcrf_pkg::ALARM_MASK_1B;
                    end
                    default: begin
                        r_alarm[i_idx] <= i_wdata;
                    end
                endcase
            end
        end
    end

    assign mem_rd = in_range ? r_mem[i_idx] : '0;

    assign o_view.ctrl0      = r_ctrl[0];
    assign o_view.ctrl1      = r_ctrl[1];
    assign o_view.ctrl2      = r_ctrl[2];
    assign o_view.mem_nib    = bank[0] ? mem_rd[7:4] : mem_rd[3:0];
    assign o_view.alarm_sel  = in_range ? r_alarm[i_idx] : '0;
    assign o_view.alarm10_b0 = r_alarm[10][0];

endmodule

>>> hw/rtl/rtcrf_rdmux.sv
// Read data select: BCD time digits, 12/24-hour handling, banked and control nibbles.
// Depends on rtcrf_pkg.
module rtcrf_rdmux (
    input  logic                             i_chip_type,
    input  logic [rtcrf_pkg::ADDR_W-1:0]     i_addr,
    input  rtcrf_pkg::t_time                 i_tm,
    input  rtcrf_pkg::t_regs_view            i_view,
    output logic [rtcrf_pkg::RDATA_W-1:0]    o_rdata
);

    logic [rtcrf_pkg::IDX_W-1:0] idx;
    logic [4:0] mon;
    logic [4:0] h12;
    logic       pm;
    logic       tens12;
    logic [7:0] sec_lo, sec_hi, min_lo, min_hi, hr_lo, hr_hi24;
    logic [7:0] md_lo, md_hi, mon_lo, mon_hi, yr_lo, yr_hi, wday;
    logic [7:0] hr_hi;

    assign idx = i_addr[rtcrf_pkg::ADDR_W-1:2];
    assign mon = 5'(i_tm.month_index) + 5'd1;

    assign sec_lo  = 8'(rtcrf_pkg::div10_r(8'(i_tm.seconds)));
    assign sec_hi  = 8'(rtcrf_pkg::div10_q(8'(i_tm.seconds)));
    assign min_lo  = 8'(rtcrf_pkg::div10_r(8'(i_tm.minutes)));
    assign min_hi  = 8'(rtcrf_pkg::div10_q(8'(i_tm.minutes)));
    assign hr_lo   = 8'(rtcrf_pkg::div10_r(8'(i_tm.hours)));
    assign hr_hi24 = 8'(rtcrf_pkg::div10_q(8'(i_tm.hours)));
    assign md_lo   = 8'(rtcrf_pkg::div10_r(8'(i_tm.day_of_month)));
    assign md_hi   = 8'(rtcrf_pkg::div10_q(8'(i_tm.day_of_month)));
    assign mon_lo  = 8'(rtcrf_pkg::div10_r(8'(mon)));
    assign mon_hi  = 8'(rtcrf_pkg::div10_q(8'(mon)));
    assign yr_lo   = 8'(rtcrf_pkg::div10_r(i_tm.years_since_1900));
    assign yr_hi   = 8'(rtcrf_pkg::div10_q(i_tm.years_since_1900));
    assign wday    = 8'(i_tm.weekday);

    assign pm     = i_tm.hours >= 5'd12;
    assign h12    = (i_tm.hours >= 5'd24) ? i_tm.hours - 5'd24 :
                    pm ? i_tm.hours - 5'd12 : i_tm.hours;
    assign tens12 = h12 >= 5'd10;

    always_comb begin
        if (!i_chip_type) begin
            if (i_view.ctrl2[2]) begin
                hr_hi = 8'(tens12) | (pm ? rtcrf_pkg::PM_FLAG_A : '0);
            end else begin
                hr_hi = hr_hi24;
            end
        end else if (i_view.alarm10_b0) begin
            hr_hi = hr_hi24;
        end else begin
            hr_hi = 8'(tens12) | (pm ? rtcrf_pkg::PM_FLAG_B : '0);
        end
    end

    always_comb begin
        o_rdata = '0;
        if (!i_addr[0]) begin
            o_rdata = '0;
        end else if (i_chip_type && idx < rtcrf_pkg::IDX_CTRL0 && i_view.ctrl0[1]) begin
            o_rdata = 8'(i_view.mem_nib);
        end else if (i_chip_type && idx < rtcrf_pkg::IDX_CTRL0 && i_view.ctrl0[0]) begin
            o_rdata = 8'(i_view.alarm_sel);
        end else begin
            case (idx)
                rtcrf_pkg::IDX_SEC_LO: o_rdata = sec_lo;
                rtcrf_pkg::IDX_SEC_HI: o_rdata = sec_hi;
                rtcrf_pkg::IDX_MIN_LO: o_rdata = min_lo;
                rtcrf_pkg::IDX_MIN_HI: o_rdata = min_hi;
                rtcrf_pkg::IDX_HR_LO:  o_rdata = hr_lo;
                rtcrf_pkg::IDX_HR_HI:  o_rdata = hr_hi;
                rtcrf_pkg::IDX_6:      o_rdata = i_chip_type ? wday   : md_lo;
                rtcrf_pkg::IDX_7:      o_rdata = i_chip_type ? md_lo  : md_hi;
                rtcrf_pkg::IDX_8:      o_rdata = i_chip_type ? md_hi  : mon_lo;
                rtcrf_pkg::IDX_9:      o_rdata = i_chip_type ? mon_lo : mon_hi;
                rtcrf_pkg::IDX_10:     o_rdata = i_chip_type ? mon_hi : yr_lo;
                rtcrf_pkg::IDX_11:     o_rdata = i_chip_type ? yr_lo  : yr_hi;
                rtcrf_pkg::IDX_12:     o_rdata = i_chip_type ? yr_hi  : wday;
                rtcrf_pkg::IDX_CTRL0:  o_rdata = 8'(i_view.ctrl0);
                rtcrf_pkg::IDX_CTRL1:  o_rdata = i_chip_type ? '0 : 8'(i_view.ctrl1);
                rtcrf_pkg::IDX_CTRL2:  o_rdata = i_chip_type ? '0 : 8'(i_view.ctrl2);
                default:               o_rdata = '0;
            endcase
        end
    end

endmodule

>>> hw/rtl/rtc_chip_register_file.sv
// Top level of the RTC register file: input register, register state, read
// select and result register. Depends on rtcrf_pkg, rtcrf_regs, rtcrf_rdmux.
//
//  channel   | direction | beat
//  ----------+-----------+------------------------------------------------
//  s_axis    | in        | one bus access: tuser = operation, tdata = address,
//            |           | write data and current time
//  m_axis    | out       | one result per access: tdata = read_data
//  apb       | in/out    | chip_type at address 0
//
// The beat is held in the input register, then the state write and read select
// resolve into the result register.
// One beat per cycle sustained; the pipeline stalls only under m_axis back-pressure.
// Synchronous active-low reset clears valids, chip_type and all register state.
module rtc_chip_register_file (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [5:0] byte_address, [13:6] write_data, [19:14] seconds, [25:20] minutes,
    // [30:26] hours, [35:31] day_of_month, [39:36] month_index,
    // [47:40] years_since_1900, [50:48] weekday, [55:51] zero
    input  logic [rtcrf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] operation
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [7:0] read_data
    output logic [rtcrf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rtcrf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rtcrf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rtcrf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready
);

    rtcrf_pkg::t_item      r_in;
    rtcrf_pkg::t_item      n_in;
    rtcrf_pkg::t_regs_view view;
    logic                  r_in_valid;
    logic                  r_out_valid;
    logic [rtcrf_pkg::RDATA_W-1:0] r_rdata;
    logic [rtcrf_pkg::RDATA_W-1:0] rd_data;
    logic                  r_chip_type;
    logic                  advance;
    logic                  wr_en;
    logic                  cfg_sel;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign wr_en         = r_in_valid && advance && (r_in.operation == rtcrf_pkg::OP_WRITE);

    assign n_in.operation           = s_axis_tuser;
    assign n_in.byte_address        = s_axis_tdata[5:0];
    assign n_in.write_data          = s_axis_tdata[13:6];
    assign n_in.tm.seconds          = s_axis_tdata[19:14];
    assign n_in.tm.minutes          = s_axis_tdata[25:20];
    assign n_in.tm.hours            = s_axis_tdata[30:26];
    assign n_in.tm.day_of_month     = s_axis_tdata[35:31];
    assign n_in.tm.month_index      = s_axis_tdata[39:36];
    assign n_in.tm.years_since_1900 = s_axis_tdata[47:40];
    assign n_in.tm.weekday          = s_axis_tdata[50:48];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= n_in;
        end
        if (advance && r_in_valid) begin
            r_rdata <= (r_in.operation == rtcrf_pkg::OP_WRITE) ? '0 : rd_data;
        end
    end

    rtcrf_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_chip_type (r_chip_type),
        .i_wr_en     (wr_en),
        .i_idx       (r_in.byte_address[rtcrf_pkg::ADDR_W-1:2]),
        .i_wdata     (r_in.write_data[rtcrf_pkg::NIB_W-1:0]),
        .o_view      (view)
    );

    rtcrf_rdmux u_rdmux (
        .i_chip_type (r_chip_type),
        .i_addr      (r_in.byte_address),
        .i_tm        (r_in.tm),
        .i_view      (view),
        .o_rdata     (rd_data)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_rdata;

    assign pready  = 1'b1;
    assign cfg_sel = paddr == rtcrf_pkg::REG_CHIP_TYPE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_type <= 1'b0;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            r_chip_type <= pwdata[0];
        end
    end

    assign prdata = cfg_sel ? rtcrf_pkg::APB_DATA_W'(r_chip_type) : '0;

endmodule

>>> hw/rtl/rtcrf_checker.sv
// Port-level checker for the RTC register file and its bind to the top level.
// Depends on rtcrf_pkg and rtc_chip_register_file.
module rtcrf_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [rtcrf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_empty_takes_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result stage");

    a_stall_keeps_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped under stall");

    a_stall_keeps_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed under stall");

endmodule

bind rtc_chip_register_file rtcrf_checker u_rtcrf_checker (.*);
